/* rtl/core/bcmp_pkg.sv */
package bcmp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_AC1_AC2_AC3_B1 = 2'd0;
    localparam logic [1:0] CFG_B2_MC_MD       = 2'd1;
    localparam logic [1:0] CFG_AC4_AC5_AC6    = 2'd2;
    localparam logic [1:0] CFG_OVERSAMPLING   = 2'd3;

    localparam int DIV_W = 32;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] P_SCALE     = 32'd50000;
    localparam logic [31:0] B4_BIAS     = 32'd32768;
    localparam logic [31:0] PC_SQ_COEF  = 32'd3038;
    localparam logic [31:0] PC_LIN_COEF = 32'hFFFF_E343; // -7357
    localparam logic [31:0] PC_OFFSET   = 32'd3791;

    typedef struct packed {
        logic [16:0] x1;
        logic        neg;
        logic        dz;
        logic [23:0] up;
    } bcmp_tside_t;

    typedef struct packed {
        logic [15:0] t;
        logic        big;
        logic        err;
    } bcmp_pside_t;

    typedef struct packed {
        logic [15:0] t;
        logic [31:0] p;
        logic        err;
    } bcmp_res_t;

    function automatic logic [31:0] sx32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

/* rtl/core/bcmp_div.sv */
module bcmp_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      quotient,
    output logic [SIDE_W-1:0] out_side
);
    logic              v_reg    [W];
    logic [W-1:0]      rem_reg  [W];
    logic [W-1:0]      quo_reg  [W];
    logic [W-1:0]      dvs_reg  [W];
    logic [SIDE_W-1:0] side_reg [W];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < W; k++) begin : g_st
        logic              v_prev;
        logic [W-1:0]      rem_prev;
        logic [W-1:0]      quo_prev;
        logic [W-1:0]      dvs_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [W:0]        rem_sh;
        logic              ge;
        logic [W-1:0]      rem_next;
        logic [W-1:0]      quo_next;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign quo_prev  = dividend;
            assign dvs_prev  = divisor;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh   = {rem_prev, quo_prev[W-1]};
            ge       = rem_sh >= {1'b0, dvs_prev};
            rem_next = ge ? W'(rem_sh - {1'b0, dvs_prev}) : rem_sh[W-1:0];
            quo_next = {quo_prev[W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            quo_reg[k]  <= quo_next;
            dvs_reg[k]  <= dvs_prev;
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = v_reg[W-1];
    assign quotient  = quo_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

/* rtl/core/bcmp_pcomp.sv */
module bcmp_pcomp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bcmp_pkg::bcmp_res_t in_res,
    output logic                out_valid,
    output bcmp_pkg::bcmp_res_t out_res
);
    import bcmp_pkg::*;

    logic        va_reg, vb_reg, vc_reg;
    bcmp_res_t   ra_reg, rb_reg, rc_reg;
    logic [31:0] sq_reg, lin_reg, sqc_reg, lin_b_reg;
    logic [31:0] s8;
    logic [31:0] corr;
    bcmp_res_t   rc_next;

    assign s8 = asr(in_res.p, 8);

    always_comb
    begin
        corr    = asr(asr(sqc_reg, 16) + asr(lin_b_reg, 16) + PC_OFFSET, 4);
        rc_next = rb_reg;
        rc_next.p = rb_reg.p + corr;
        // force zero outputs on a divide error
        if (rb_reg.err)
        begin
            rc_next.p = '0;
            rc_next.t = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg    <= in_res;
        sq_reg    <= s8 * s8;
        lin_reg   <= PC_LIN_COEF * in_res.p;
        rb_reg    <= ra_reg;
        sqc_reg   <= sq_reg * PC_SQ_COEF;
        lin_b_reg <= lin_reg;
        rc_reg    <= rc_next;
    end

    assign out_valid = vc_reg;
    assign out_res   = rc_reg;

endmodule

/* rtl/core/barometric_compensation.sv */
// Channel   Ports                                          Handshake
// input     raw_temperature, raw_pressure                  start & !busy
// result    temperature_tenths, pressure_pa, divide_error  done (one cycle)
// config    cfg_index, cfg_wdata                           cfg_we
//
// One transaction per cycle; each result passes through the two radix-2
// divider pipelines plus 12 stages of multiply and add. busy stays low:
// the pipeline never holds.
// Reset clears the calibration registers and every valid bit.
// The receiver cannot stall; results leave on the done strobe.
module barometric_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic [15:0] raw_temperature,
    input  logic [23:0] raw_pressure,
    output logic        done,
    output logic signed [15:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic        divide_error
);
    import bcmp_pkg::*;

    localparam int LAT = 12 + 2 * DIV_W;

    logic [63:0] cal0_reg;
    logic [47:0] cal1_reg, cal2_reg;
    logic [1:0]  oss_reg;

    logic [15:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;

    assign ac1 = cal0_reg[63:48];
    assign ac2 = cal0_reg[47:32];
    assign ac3 = cal0_reg[31:16];
    assign b1  = cal0_reg[15:0];
    assign b2  = cal1_reg[47:32];
    assign mc  = cal1_reg[31:16];
    assign md  = cal1_reg[15:0];
    assign ac4 = cal2_reg[47:32];
    assign ac5 = cal2_reg[31:16];
    assign ac6 = cal2_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal0_reg <= '0;
            cal1_reg <= '0;
            cal2_reg <= '0;
            oss_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AC1_AC2_AC3_B1: cal0_reg <= cfg_wdata;
                CFG_B2_MC_MD:       cal1_reg <= cfg_wdata[47:0];
                CFG_AC4_AC5_AC6:    cal2_reg <= cfg_wdata[47:0];
                CFG_OVERSAMPLING:   oss_reg  <= cfg_wdata[1:0];
                default:            oss_reg  <= oss_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- temperature front ----------------
    logic               accept;
    logic signed [16:0] ut_diff;
    logic signed [33:0] ut_prod;

    assign accept  = start && !busy;
    assign ut_diff = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
    assign ut_prod = ut_diff * $signed({1'b0, ac5});

    logic        v1_reg;
    logic [31:0] prod1_reg;
    logic [23:0] up1_reg;

    logic signed [18:0] den;
    logic signed [26:0] num;

    assign den = $signed({2'b0, prod1_reg[31:15]}) + $signed({{3{md[15]}}, md});
    assign num = $signed({mc, 11'b0});

    logic        v2_reg;
    logic [31:0] num_mag_reg, den_mag_reg;
    bcmp_tside_t ts2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg   <= ut_prod[31:0];
        up1_reg     <= raw_pressure >> (4'd8 - {2'b0, oss_reg});
        num_mag_reg <= num[26] ? -32'(num) : 32'(num);
        den_mag_reg <= den[18] ? -32'(den) : 32'(den);
        ts2_reg.x1  <= prod1_reg[31:15];
        ts2_reg.neg <= num[26] ^ den[18];
        ts2_reg.dz  <= den == '0;
        ts2_reg.up  <= up1_reg;
    end

    logic        d1_valid;
    logic [31:0] d1_quo;
    bcmp_tside_t d1_side;

    bcmp_div #(
        .W      (DIV_W),
        .SIDE_W ($bits(bcmp_tside_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .dividend  (num_mag_reg),
        .divisor   (den_mag_reg),
        .in_side   (ts2_reg),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .out_side  (d1_side)
    );

    // ---------------- pressure polynomial ----------------
    logic        vb5_reg, vm1_reg, vm2_reg, vm3_reg, vm4_reg, vm5_reg;
    logic [31:0] b5_reg;
    logic        dz_b5_reg, dz_m1_reg, dz_m2_reg, dz_m3_reg, dz_m4_reg, dz_m5_reg;
    logic [23:0] up_b5_reg, up_m1_reg, up_m2_reg, up_m3_reg, up_m4_reg;
    logic [15:0] t_m1_reg, t_m2_reg, t_m3_reg, t_m4_reg, t_m5_reg;
    logic [31:0] b6sq_p_reg, ac2p_reg, ac3p_reg;
    logic [31:0] ac2p_m2_reg, ac3p_m2_reg, b2p_reg, b1p_reg;
    logic [31:0] x3a_reg, x3b_reg;
    logic [31:0] b3_reg, b4p_reg;
    logic [16:0] b4_reg;
    logic [31:0] b7_reg;

    logic [31:0] qs, tt, b6, b6sq, b3_pre, x3b_q, b4_m5;
    logic [15:0] t_sat;

    always_comb
    begin
        qs = d1_side.neg ? 32'(-d1_quo) : d1_quo;
        tt = asr(b5_reg + 32'd8, 4);
        if ($signed(tt) > 32'sd32767)
            t_sat = 16'h7FFF;
        else if ($signed(tt) < -32'sd32768)
            t_sat = 16'h8000;
        else
            t_sat = tt[15:0];
        b6     = b5_reg - B6_OFFSET;
        b6sq   = asr(b6sq_p_reg, 12);
        b3_pre = ((sx32(ac1) << 2) + x3a_reg) << oss_reg;
        x3b_q  = asr(x3b_reg, 2) + B4_BIAS;
        b4_m5  = b4p_reg >> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb5_reg <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
            vm4_reg <= 1'b0;
            vm5_reg <= 1'b0;
        end
        else
        begin
            vb5_reg <= d1_valid;
            vm1_reg <= vb5_reg;
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
            vm4_reg <= vm3_reg;
            vm5_reg <= vm4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b5_reg      <= {15'b0, d1_side.x1} + qs;
        dz_b5_reg   <= d1_side.dz;
        up_b5_reg   <= d1_side.up;

        t_m1_reg    <= t_sat;
        b6sq_p_reg  <= b6 * b6;
        ac2p_reg    <= sx32(ac2) * b6;
        ac3p_reg    <= sx32(ac3) * b6;
        dz_m1_reg   <= dz_b5_reg;
        up_m1_reg   <= up_b5_reg;

        b2p_reg     <= sx32(b2) * b6sq;
        b1p_reg     <= sx32(b1) * b6sq;
        ac2p_m2_reg <= ac2p_reg;
        ac3p_m2_reg <= ac3p_reg;
        t_m2_reg    <= t_m1_reg;
        dz_m2_reg   <= dz_m1_reg;
        up_m2_reg   <= up_m1_reg;

        x3a_reg     <= asr(b2p_reg, 11) + asr(ac2p_m2_reg, 11);
        x3b_reg     <= asr(ac3p_m2_reg, 13) + asr(b1p_reg, 16) + 32'd2;
        t_m3_reg    <= t_m2_reg;
        dz_m3_reg   <= dz_m2_reg;
        up_m3_reg   <= up_m2_reg;

        b3_reg      <= asr(b3_pre + 32'd2, 2);
        b4p_reg     <= {16'b0, ac4} * x3b_q;
        t_m4_reg    <= t_m3_reg;
        dz_m4_reg   <= dz_m3_reg;
        up_m4_reg   <= up_m3_reg;

        b4_reg      <= b4_m5[16:0];
        b7_reg      <= ({8'b0, up_m4_reg} - b3_reg) * (P_SCALE >> oss_reg);
        t_m5_reg    <= t_m4_reg;
        dz_m5_reg   <= dz_m4_reg;
    end

    // double small dividends first; large ones are divided as is and the quotient doubled after
    bcmp_pside_t ps_in;
    logic [31:0] d2_dvd;

    always_comb
    begin
        ps_in.t   = t_m5_reg;
        ps_in.big = b7_reg[31];
        ps_in.err = dz_m5_reg || (b4_reg == '0);
        d2_dvd    = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
    end

    logic        d2_valid;
    logic [31:0] d2_quo;
    bcmp_pside_t d2_side;

    bcmp_div #(
        .W      (DIV_W),
        .SIDE_W ($bits(bcmp_pside_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vm5_reg),
        .dividend  (d2_dvd),
        .divisor   ({15'b0, b4_reg}),
        .in_side   (ps_in),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .out_side  (d2_side)
    );

    logic      vp_reg;
    bcmp_res_t rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg.t   <= d2_side.t;
        rp_reg.p   <= d2_side.big ? {d2_quo[30:0], 1'b0} : d2_quo;
        rp_reg.err <= d2_side.err;
    end

    logic      out_valid;
    bcmp_res_t out_res;

    bcmp_pcomp u_pcomp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vp_reg),
        .in_res    (rp_reg),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign done               = out_valid;
    assign temperature_tenths = $signed(out_res.t);
    assign pressure_pa        = $signed(out_res.p);
    assign divide_error       = out_res.err;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a transaction at the pipeline latency");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_error |-> temperature_tenths == 16'sd0 && pressure_pa == 32'sd0)
        else $error("divide error with nonzero outputs");

    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg)
        else $error("front stage dropped a transaction");

    a_b4_err: assert property (@(posedge clk) disable iff (!rst_n)
        vm5_reg && b4_reg == '0 |-> ps_in.err)
        else $error("zero pressure divisor not flagged");
`endif

endmodule

/* test/barometric_compensation_tb.sv */
module barometric_compensation_tb;
    import bcmp_pkg::*;

    localparam int LATENCY     = 76;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] tenths;
        logic [31:0] pascals;
        logic        div_err;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic [15:0] raw_temperature = '0;
    logic [23:0] raw_pressure = '0;
    logic        done;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic        divide_error;

    // local copy of the calibration registers
    logic [63:0] coef_a;
    logic [47:0] coef_b;
    logic [47:0] coef_u;
    logic [1:0]  oss;

    reading_t    pending_readings[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;

    barometric_compensation u_dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut, input logic [23:0] rawp);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b6sq, b7, up, p, den, tsh;
        logic [63:0] prod;
        int signed t;
        ac1 = {{16{coef_a[63]}}, coef_a[63:48]};
        ac2 = {{16{coef_a[47]}}, coef_a[47:32]};
        ac3 = {{16{coef_a[31]}}, coef_a[31:16]};
        b1  = {{16{coef_a[15]}}, coef_a[15:0]};
        b2  = {{16{coef_b[47]}}, coef_b[47:32]};
        mc  = {{16{coef_b[31]}}, coef_b[31:16]};
        md  = {{16{coef_b[15]}}, coef_b[15:0]};
        ac4 = {16'd0, coef_u[47:32]};
        ac5 = {16'd0, coef_u[31:16]};
        ac6 = {16'd0, coef_u[15:0]};
        r.tenths = '0;
        r.pascals = '0;
        r.div_err = 1'b1;
        x1 = 32'((32'(ut) - ac6) * ac5) >> 15;
        den = x1 + md;
        if (den == 0)
            return r;
        b5 = x1 + 32'($signed(32'(mc * 32'd2048)) / $signed(den));
        tsh = sra32(b5 + 32'd8, 4);
        t = $signed(tsh);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        up = 32'(rawp) >> (8 - oss);
        b6 = b5 - B6_OFFSET;
        b6sq = sra32(32'(b6 * b6), 12);
        x1 = sra32(32'(b2 * b6sq), 11);
        x2 = sra32(32'(ac2 * b6), 11);
        x3 = x1 + x2;
        b3 = sra32(32'(((ac1 * 32'd4 + x3) << oss) + 32'd2), 2);
        x1 = sra32(32'(ac3 * b6), 13);
        x2 = sra32(32'(b1 * b6sq), 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        prod = 64'(ac4) * 64'(32'(x3 + 32'd32768));
        b4 = prod[31:0] >> 15;
        if (b4 == 0)
            return r;
        b7 = 32'((up - b3) * (32'd50000 >> oss));
        if (b7 < 32'h8000_0000)
            p = 32'(b7 * 32'd2) / b4;
        else
            p = 32'((b7 / b4) * 32'd2);
        x1 = 32'(sra32(p, 8) * sra32(p, 8));
        x1 = sra32(32'(x1 * 32'd3038), 16);
        x2 = sra32(32'(32'hFFFF_E343 * p), 16);
        p = p + sra32(x1 + x2 + 32'd3791, 4);
        r.tenths = 16'(t);
        r.pascals = p;
        r.div_err = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                e = pending_readings.pop_front();
                if (temperature_tenths !== e.tenths)
                    report_mismatch($sformatf("temperature %0d, want %0d",
                        temperature_tenths, $signed(e.tenths)));
                if (pressure_pa !== e.pascals)
                    report_mismatch($sformatf("pressure %0d, want %0d",
                        pressure_pa, $signed(e.pascals)));
                if (divide_error !== e.div_err)
                    report_mismatch($sformatf("divide_error %b, want %b",
                        divide_error, e.div_err));
            end
        end
    end

    task automatic send_sample(input logic [15:0] ut, input logic [23:0] rawp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        raw_temperature <= ut;
        raw_pressure <= rawp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_readings.push_back(compensate(ut, rawp));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_AC1_AC2_AC3_B1: coef_a = val;
            CFG_B2_MC_MD:       coef_b = val[47:0];
            CFG_AC4_AC5_AC6:    coef_u = val[47:0];
            default:            oss = val[1:0];
        endcase
    endtask

    // typical datasheet calibration
    task automatic load_typical(input logic [1:0] o);
        write_reg(CFG_AC1_AC2_AC3_B1, {16'd408, -16'sd72, -16'sd14383, 16'd6190});
        write_reg(CFG_B2_MC_MD, 64'({$urandom(), 16'd4, -16'sd8711, 16'd2868}));
        write_reg(CFG_AC4_AC5_AC6, 64'({$urandom(), 16'd32741, 16'd32757, 16'd23153}));
        write_reg(CFG_OVERSAMPLING, {$urandom(), $urandom()} & ~64'h3 | 64'(o));
    endtask

    task automatic test_zero_calibration();
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_directed_extremes();
        load_typical(2'd0);
        send_sample(16'd27898, 24'h5D23_00);
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'd100, 24'h800000);
        drain();
        load_typical(2'd3);
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'h0000, 24'hFFFFFF);
        send_sample(16'hFFFF, 24'h000000);
        drain();
        // zero temperature divisor: ac5 = 0 so x1 = 0, md = 0
        write_reg(CFG_AC4_AC5_AC6, 64'({16'd32741, 16'd0, 16'd23153}));
        write_reg(CFG_B2_MC_MD, 64'({16'd4, -16'sd8711, 16'd0}));
        send_sample(16'd27898, 24'h5D2300);
        drain();
        // zero pressure divisor: ac4 = 0
        write_reg(CFG_B2_MC_MD, 64'({16'd4, -16'sd8711, 16'd2868}));
        write_reg(CFG_AC4_AC5_AC6, 64'({16'd0, 16'd32757, 16'd23153}));
        send_sample(16'd27898, 24'h5D2300);
        drain();
        write_reg(CFG_AC1_AC2_AC3_B1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_B2_MC_MD, 64'hFFFF_7FFF_7FFF_8000);
        write_reg(CFG_AC4_AC5_AC6, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(16'h0000, 24'hFFFFFF);
        send_sample(16'hFFFF, 24'hABCDEF);
        drain();
    endtask

    task automatic test_random_samples(input int count, input int idle_pct);
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                send_sample(16'($urandom()), 24'($urandom()));
            else
                send_sample(16'($urandom_range(20000, 40000)),
                            24'($urandom_range(24'h300000, 24'hA00000)));
        end
        drain();
        send_idle_pct = 0;
    endtask

    task automatic test_random_calibration(input int idle_pct);
        for (int k = 0; k < 6; k++)
        begin
            write_reg(CFG_AC1_AC2_AC3_B1, {$urandom(), $urandom()});
            write_reg(CFG_B2_MC_MD, {$urandom(), $urandom()});
            write_reg(CFG_AC4_AC5_AC6, {$urandom(), $urandom()});
            write_reg(CFG_OVERSAMPLING, 64'($urandom_range(3)));
            test_random_samples(60, idle_pct);
        end
    endtask

    initial
    begin
        coef_a = '0;
        coef_b = '0;
        coef_u = '0;
        oss = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_calibration();
        test_directed_extremes();
        for (int o = 0; o < 4; o++)
        begin
            load_typical(2'(o));
            test_random_samples(200, o == 0 ? 31 : (o == 1 ? 67 : 0));
        end
        test_random_calibration(31);
        test_random_calibration(67);
        test_random_calibration(0);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
